// File: rtl/core/char_lcd_nibble_write_sequencer_macros.svh
// Assertion macros shared by the queue and back-end modules.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define LCDNS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define LCDNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define LCDNS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LCDNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/lcdns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcdns_pkg;

	// Request function codes.
	localparam logic [1:0] FUNC_COMMAND = 2'd0;
	localparam logic [1:0] FUNC_CHAR    = 2'd1;
	localparam logic [1:0] FUNC_CURSOR  = 2'd2;
	localparam logic [1:0] FUNC_POWERUP = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_POWER_ON_WAIT = 2'd0;
	localparam logic [1:0] REG_ENABLE_HIGH   = 2'd1;
	localparam logic [1:0] REG_ENABLE_LOW    = 2'd2;
	localparam logic [1:0] REG_DATA_SETUP    = 2'd3;

	// Reset values of the timing registers, in milliseconds.
	localparam logic [7:0] RST_POWER_ON_WAIT = 8'd20;
	localparam logic [7:0] RST_ENABLE_HIGH   = 8'd1;
	localparam logic [7:0] RST_ENABLE_LOW    = 8'd1;
	localparam logic [7:0] RST_DATA_SETUP    = 8'd1;

	// Pulse counter: a power-up request sends six bytes, twelve pulses.
	localparam int unsigned POWERUP_BYTES = 6;
	localparam int unsigned STEP_W = $clog2(2 * POWERUP_BYTES);
	localparam logic [STEP_W-1:0] LAST_POWERUP_STEP = STEP_W'(2 * POWERUP_BYTES - 1);

	// Cursor addressing command bit.
	localparam logic CURSOR_CMD_BIT = 1'b1;

	// Queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		DESC_INSTR = 2'd0,
		DESC_DATA  = 2'd1,
		DESC_POWERUP = 2'd2
	} lcdns_kind_t;

	// One classified request as the back end carries it out.
	typedef struct packed {
		lcdns_kind_t kind;
		logic [7:0]  cmd_byte;
	} lcdns_desc_t;

	// Front to queue push request.
	typedef struct packed {
		logic        valid;
		lcdns_desc_t desc;
	} lcdns_push_t;

	// Queue occupancy seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} lcdns_qstat_t;

	// Power-up command bytes in the order they are sent.
	function automatic logic [7:0] powerup_cmd(input logic [STEP_W-2:0] idx);
		logic [7:0] cmd;
		unique case (idx)
			3'd0: cmd = 8'h33;
			3'd1: cmd = 8'h32;
			3'd2: cmd = 8'h28;
			3'd3: cmd = 8'h0C;
			3'd4: cmd = 8'h06;
			3'd5: cmd = 8'h01;
			default: cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/lcdns_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdns_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// Fields from bit 0: func[1:0], byte_value[9:2], row[10], col[16:11], zero fill.
	input  wire logic [23:0]          s_axis_tdata,
	output lcdns_pkg::lcdns_push_t    push,
	input  wire lcdns_pkg::lcdns_qstat_t qstat
);

	logic [1:0] func;
	logic [7:0] byte_value;
	logic       row;
	logic [5:0] col;
	logic       accept;
	logic       push_ok;
	logic       valid_s1;
	lcdns_pkg::lcdns_desc_t desc_next;
	lcdns_pkg::lcdns_desc_t desc_s1;

	assign func       = s_axis_tdata[1:0];
	assign byte_value = s_axis_tdata[9:2];
	assign row        = s_axis_tdata[10];
	assign col        = s_axis_tdata[16:11];

	// The stage register frees up whenever the queue takes its item.
	assign push_ok       = valid_s1 && !qstat.full;
	assign s_axis_tready = !valid_s1 || push_ok;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Classify the request. A cursor address has bit 6 set exactly for row 1,
	// since the column never reaches 64.
	always_comb begin
		desc_next.cmd_byte = byte_value;
		unique case (func)
			lcdns_pkg::FUNC_COMMAND: begin
				desc_next.kind = lcdns_pkg::DESC_INSTR;
			end
			lcdns_pkg::FUNC_CHAR: begin
				desc_next.kind = lcdns_pkg::DESC_DATA;
			end
			lcdns_pkg::FUNC_CURSOR: begin
				desc_next.kind     = lcdns_pkg::DESC_INSTR;
				desc_next.cmd_byte = {lcdns_pkg::CURSOR_CMD_BIT, row, col};
			end
			lcdns_pkg::FUNC_POWERUP: begin
				desc_next.kind = lcdns_pkg::DESC_POWERUP;
			end
		endcase
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ok) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_next;
		end
	end

	assign push.valid = valid_s1;
	assign push.desc  = desc_s1;

endmodule

`default_nettype wire

// File: rtl/core/lcdns_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_nibble_write_sequencer_macros.svh"

module lcdns_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lcdns_pkg::lcdns_push_t push,
	input  wire logic                   pop,
	output lcdns_pkg::lcdns_desc_t      head,
	output lcdns_pkg::lcdns_qstat_t     qstat
);

	lcdns_pkg::lcdns_desc_t mem_q [lcdns_pkg::QUEUE_DEPTH];
	logic [lcdns_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lcdns_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lcdns_pkg::QCNT_W-1:0] count_q;
	logic                         do_push;

	assign qstat.full  = (count_q == lcdns_pkg::QCNT_W'(lcdns_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push.valid && !qstat.full;
	assign head        = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.desc;
		end
	end

	`LCDNS_ASSERT_NOW(a_pop_not_empty, clk, arst_n, pop, !qstat.empty)
	`LCDNS_ASSERT_NOW(a_count_in_range, clk, arst_n, 1'b1, count_q <= lcdns_pkg::QCNT_W'(lcdns_pkg::QUEUE_DEPTH))
	`LCDNS_ASSERT_NEXT(a_push_lands, clk, arst_n, do_push && !pop, !qstat.empty)

endmodule

`default_nettype wire

// File: rtl/core/lcdns_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_nibble_write_sequencer_macros.svh"

module lcdns_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [7:0]              cfg_wdata,
	input  wire lcdns_pkg::lcdns_desc_t  head,
	input  wire lcdns_pkg::lcdns_qstat_t qstat,
	output logic                         pop,
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	// Fields from bit 0: nibble[3:0], setup_time[11:4], high_time[19:12],
	// low_time[27:20], zero fill.
	output logic [31:0]                  m_axis_tdata,
	output logic                         m_axis_tlast,
	// Fields from bit 0: register_select[0].
	output logic                         m_axis_tuser
);

	logic [7:0] power_on_wait_q;
	logic [7:0] enable_high_q;
	logic [7:0] enable_low_q;
	logic [7:0] data_setup_q;

	logic                             cur_valid_q;
	lcdns_pkg::lcdns_desc_t           cur_q;
	logic [lcdns_pkg::STEP_W-1:0]     step_q;

	logic                             out_adv;
	logic                             fire;
	logic                             is_last;
	logic                             load;
	logic [7:0]                       cur_byte;
	logic [3:0]                       nibble;
	logic [7:0]                       setup_time;
	logic                             rs;

	logic                             m_valid_q;
	logic [3:0]                       nibble_q;
	logic [7:0]                       setup_q;
	logic [7:0]                       high_q;
	logic [7:0]                       low_q;
	logic                             last_q;
	logic                             rs_q;

	// Timing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on_wait_q <= lcdns_pkg::RST_POWER_ON_WAIT;
			enable_high_q   <= lcdns_pkg::RST_ENABLE_HIGH;
			enable_low_q    <= lcdns_pkg::RST_ENABLE_LOW;
			data_setup_q    <= lcdns_pkg::RST_DATA_SETUP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcdns_pkg::REG_POWER_ON_WAIT: power_on_wait_q <= cfg_wdata;
				lcdns_pkg::REG_ENABLE_HIGH:   enable_high_q   <= cfg_wdata;
				lcdns_pkg::REG_ENABLE_LOW:    enable_low_q    <= cfg_wdata;
				lcdns_pkg::REG_DATA_SETUP:    data_setup_q    <= cfg_wdata;
			endcase
		end
	end

	// Pulse decode for the current step: even steps carry the high nibble.
	always_comb begin
		is_last    = cur_q.kind == lcdns_pkg::DESC_POWERUP ?
			(step_q == lcdns_pkg::LAST_POWERUP_STEP) : step_q[0];
		cur_byte   = cur_q.kind == lcdns_pkg::DESC_POWERUP ?
			lcdns_pkg::powerup_cmd(step_q[lcdns_pkg::STEP_W-1:1]) : cur_q.cmd_byte;
		nibble     = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
		rs         = 1'b0;
		setup_time = 8'd0;
		unique case (cur_q.kind)
			lcdns_pkg::DESC_DATA: begin
				rs         = 1'b1;
				setup_time = data_setup_q;
			end
			lcdns_pkg::DESC_POWERUP: begin
				if (step_q == '0) begin
					setup_time = power_on_wait_q;
				end
			end
			default: begin
				setup_time = 8'd0;
			end
		endcase
	end

	// One pulse per cycle while the output register can take it; the next
	// request is loaded as the last pulse of the current one leaves.
	assign out_adv = !m_valid_q || m_axis_tready;
	assign fire    = cur_valid_q && out_adv;
	assign load    = !cur_valid_q || (fire && is_last);
	assign pop     = load && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				cur_valid_q <= !qstat.empty;
			end
			if (pop) begin
				step_q <= '0;
			end else if (fire) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			nibble_q <= nibble;
			setup_q  <= setup_time;
			high_q   <= enable_high_q;
			low_q    <= enable_low_q;
			last_q   <= is_last;
			rs_q     <= rs;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'd0, low_q, high_q, setup_q, nibble_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = rs_q;

	`LCDNS_ASSERT_NOW(a_byte_step_range, clk, arst_n, cur_valid_q && cur_q.kind != lcdns_pkg::DESC_POWERUP, step_q <= lcdns_pkg::STEP_W'(1))
	`LCDNS_ASSERT_NOW(a_powerup_step_range, clk, arst_n, cur_valid_q, step_q <= lcdns_pkg::LAST_POWERUP_STEP)
	`LCDNS_ASSERT_NEXT(a_drain_to_idle, clk, arst_n, fire && is_last && qstat.empty, !cur_valid_q)
	`LCDNS_ASSERT_NEXT(a_fire_shows, clk, arst_n, fire, m_valid_q)

endmodule

`default_nettype wire

// File: rtl/core/char_lcd_nibble_write_sequencer.sv
// A request passes the front-end stage register, the queue and the current-request register
// on its way to the output register. The back end sends one pulse per cycle while the output
// is not stalled: two for a command, character or cursor request, twelve for a power-up.
// The input side takes a request every cycle until the two-entry queue fills.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the timing defaults.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_write_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// Fields from bit 0: func[1:0], byte_value[9:2], row[10], col[16:11], zero fill.
	input  wire logic [23:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// Fields from bit 0: nibble[3:0], setup_time[11:4], high_time[19:12],
	// low_time[27:20], zero fill.
	output logic [31:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	// Fields from bit 0: register_select[0].
	output logic             m_axis_tuser
);

	lcdns_pkg::lcdns_push_t  push;
	lcdns_pkg::lcdns_qstat_t qstat;
	lcdns_pkg::lcdns_desc_t  head;
	logic                    pop;

	lcdns_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push          (push),
		.qstat         (qstat)
	);

	lcdns_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	lcdns_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// File: test/tb_char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_sequencer;
	import lcdns_pkg::*;

	// One enable pulse as it should appear on the output stream.
	typedef struct packed {
		logic [3:0] nibble;
		logic       rs;
		logic [7:0] setup;
		logic [7:0] high;
		logic [7:0] low;
		logic       last;
	} lcd_pulse_t;

	localparam logic [7:0] INIT_CMDS [0:5] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	// Local copy of the timing registers.
	logic [7:0] wait_ms;
	logic [7:0] high_ms;
	logic [7:0] low_ms;
	logic [7:0] setup_ms;

	lcd_pulse_t pulses_due[$];
	int errors = 0;
	bit idle_on = 1'b1;
	bit hold_request = 1'b0;
	int hold_left = 0;

	char_lcd_nibble_write_sequencer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Queue both nibbles of one byte, high nibble first.
	task automatic push_byte(input logic [7:0] value, input logic rs, input logic [7:0] first_setup,
			input logic [7:0] second_setup, input logic final_byte);
		pulses_due.push_back('{value[7:4], rs, first_setup, high_ms, low_ms, 1'b0});
		pulses_due.push_back('{value[3:0], rs, second_setup, high_ms, low_ms, final_byte});
	endtask

	// Work out the pulses that one accepted request produces.
	task automatic predict_pulses(input logic [23:0] word);
		logic [1:0] func;
		logic [7:0] value;
		logic       row;
		logic [5:0] col;
		logic [7:0] addr;
		func  = word[1:0];
		value = word[9:2];
		row   = word[10];
		col   = word[16:11];
		case (func)
			FUNC_COMMAND: begin
				push_byte(value, 1'b0, 8'd0, 8'd0, 1'b1);
			end
			FUNC_CHAR: begin
				push_byte(value, 1'b1, setup_ms, setup_ms, 1'b1);
			end
			FUNC_CURSOR: begin
				addr = {2'b00, col};
				if (row) begin
					addr = addr + 8'h40;
				end
				push_byte(addr | 8'h80, 1'b0, 8'd0, 8'd0, 1'b1);
			end
			default: begin
				for (int i = 0; i < 6; i++) begin
					push_byte(INIT_CMDS[i], 1'b0, (i == 0) ? wait_ms : 8'd0, 8'd0, i == 5);
				end
			end
		endcase
	endtask

	// Predict on every accepted request and check every accepted pulse.
	always @(posedge clk) begin : pulse_check
		lcd_pulse_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_pulses(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pulses_due.size() == 0) begin
					$error("unexpected pulse: tdata %h tlast %b tuser %b",
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
					errors++;
				end else begin
					want = pulses_due.pop_front();
					if (m_axis_tdata[3:0] !== want.nibble) begin
						$error("nibble: expected %h, got %h", want.nibble, m_axis_tdata[3:0]);
						errors++;
					end
					if (m_axis_tuser !== want.rs) begin
						$error("register_select: expected %b, got %b", want.rs, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[11:4] !== want.setup) begin
						$error("setup_time: expected %0d, got %0d", want.setup, m_axis_tdata[11:4]);
						errors++;
					end
					if (m_axis_tdata[19:12] !== want.high) begin
						$error("high_time: expected %0d, got %0d", want.high, m_axis_tdata[19:12]);
						errors++;
					end
					if (m_axis_tdata[27:20] !== want.low) begin
						$error("low_time: expected %0d, got %0d", want.low, m_axis_tdata[27:20]);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %b, got %b", want.last, m_axis_tlast);
						errors++;
					end
				end
			end
		end
	end

	// Output side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = 120;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (idle_on && $urandom_range(0, 99) < 25) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Offer one request and hold it until the block takes it.
	task automatic send_request(input logic [1:0] func, input logic [7:0] value, input logic row,
			input logic [5:0] col);
		if (idle_on && $urandom_range(0, 99) < 25) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, col, row, value, func};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	task automatic send_random_request();
		int pick;
		logic [1:0] func;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			func = FUNC_COMMAND;
		end else if (pick < 6) begin
			func = FUNC_CHAR;
		end else if (pick < 9) begin
			func = FUNC_CURSOR;
		end else begin
			func = FUNC_POWERUP;
		end
		send_request(func, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 63));
	endtask

	// Drop valid and wait until every expected pulse has come out. The first
	// edge lets the checker record the request accepted at the previous edge.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pulses_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		case (index)
			REG_POWER_ON_WAIT: wait_ms  = value;
			REG_ENABLE_HIGH:   high_ms  = value;
			REG_ENABLE_LOW:    low_ms   = value;
			REG_DATA_SETUP:    setup_ms = value;
		endcase
		@(posedge clk);
	endtask

	// Load all four timing registers; only called while the block is idle.
	task automatic set_timing(input logic [7:0] power_wait, input logic [7:0] high,
			input logic [7:0] low, input logic [7:0] setup);
		write_reg(REG_POWER_ON_WAIT, power_wait);
		write_reg(REG_ENABLE_HIGH, high);
		write_reg(REG_ENABLE_LOW, low);
		write_reg(REG_DATA_SETUP, setup);
		cfg_we <= 1'b0;
	endtask

	// Power-up sequence with the reset timing values.
	task automatic test_powerup_defaults();
		send_request(FUNC_POWERUP, 8'h00, 1'b0, 6'd0);
		drain();
	endtask

	task automatic test_commands();
		send_request(FUNC_COMMAND, 8'h00, 1'b0, 6'd0);
		send_request(FUNC_COMMAND, 8'hFF, 1'b1, 6'd63);
		send_request(FUNC_COMMAND, 8'hA5, 1'b0, 6'd21);
		drain();
	endtask

	task automatic test_characters();
		send_request(FUNC_CHAR, 8'h00, 1'b1, 6'd63);
		send_request(FUNC_CHAR, 8'hFF, 1'b0, 6'd0);
		send_request(FUNC_CHAR, 8'h5A, 1'b1, 6'd42);
		drain();
	endtask

	// Cursor corners of both lines, plus a column in the middle.
	task automatic test_cursor();
		send_request(FUNC_CURSOR, 8'hFF, 1'b0, 6'd0);
		send_request(FUNC_CURSOR, 8'h00, 1'b0, 6'd63);
		send_request(FUNC_CURSOR, 8'h00, 1'b1, 6'd0);
		send_request(FUNC_CURSOR, 8'hFF, 1'b1, 6'd63);
		send_request(FUNC_CURSOR, 8'h3C, 1'b1, 6'd21);
		drain();
	endtask

	// Each kind of request under both extreme timing settings and a mixed one.
	task automatic test_timing_extremes();
		set_timing(8'd0, 8'd0, 8'd0, 8'd0);
		send_request(FUNC_COMMAND, 8'h3C, 1'b0, 6'd0);
		send_request(FUNC_CHAR, 8'hC3, 1'b0, 6'd0);
		send_request(FUNC_CURSOR, 8'h00, 1'b1, 6'd5);
		send_request(FUNC_POWERUP, 8'h00, 1'b0, 6'd0);
		drain();
		set_timing(8'd255, 8'd255, 8'd255, 8'd255);
		send_request(FUNC_COMMAND, 8'h81, 1'b1, 6'd0);
		send_request(FUNC_CHAR, 8'h7E, 1'b0, 6'd0);
		send_request(FUNC_CURSOR, 8'h00, 1'b0, 6'd40);
		send_request(FUNC_POWERUP, 8'hFF, 1'b1, 6'd63);
		drain();
		set_timing(8'd170, 8'd85, 8'd15, 8'd240);
		send_request(FUNC_CHAR, 8'h41, 1'b0, 6'd0);
		send_request(FUNC_POWERUP, 8'h00, 1'b0, 6'd0);
		send_request(FUNC_COMMAND, 8'h01, 1'b0, 6'd0);
		send_request(FUNC_CURSOR, 8'h00, 1'b1, 6'd39);
		drain();
	endtask

	// Hold the output off while requests keep coming, so the input stalls.
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_request = 1'b1;
		repeat (20) send_random_request();
		drain();
		idle_on = 1'b1;
	endtask

	// Random traffic in phases, each with its own timing setting.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			set_timing($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255));
			idle_on = (phase != 2);
			repeat (59) send_random_request();
			drain();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_POWER_ON_WAIT;
		cfg_wdata     = 8'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 24'd0;
		m_axis_tready = 1'b0;
		wait_ms       = RST_POWER_ON_WAIT;
		high_ms       = RST_ENABLE_HIGH;
		low_ms        = RST_ENABLE_LOW;
		setup_ms      = RST_DATA_SETUP;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_powerup_defaults();
		test_commands();
		test_characters();
		test_cursor();
		test_timing_extremes();
		test_backpressure();
		test_random_traffic();

		if (pulses_due.size() != 0) begin
			$error("%0d expected pulses never arrived", pulses_due.size());
			errors++;
		end
		if (errors == 0) begin
			$display("char_lcd_nibble_write_sequencer verification clean");
		end else begin
			$display("char_lcd_nibble_write_sequencer verification failed");
		end
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#3_000_000;
		$display("char_lcd_nibble_write_sequencer verification failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/lcdns_pkg.sv
rtl/core/lcdns_front.sv
rtl/core/lcdns_queue.sv
rtl/core/lcdns_back.sv
rtl/core/char_lcd_nibble_write_sequencer.sv
test/tb_char_lcd_nibble_write_sequencer.sv
